// ===== src/bla_pkg.sv =====
// Shared types and codes for the buddy leaf context allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bla_pkg;

  localparam int NUM_LEAVES   = 8;
  localparam int NUM_CONTEXTS = 8;

  localparam logic       CMD_ALLOCATE = 1'b0;
  localparam logic       CMD_RELEASE  = 1'b1;

  localparam logic       KIND_DISPATCH = 1'b0;
  localparam logic       KIND_ACK      = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_STALE    = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  localparam logic [1:0] LEVEL_LEAF = 2'd0;
  localparam logic [1:0] LEVEL_PAIR = 2'd1;
  localparam logic [1:0] LEVEL_QUAD = 2'd2;
  localparam logic [1:0] LEVEL_ROOT = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] row;
    logic [31:0] extra;
    logic [7:0]  src_select;
    logic [2:0]  context_req;
    logic [7:0]  generation;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [2:0]  context_out;
    logic [7:0]  generation_out;
    logic [7:0]  granted_leaves;
    logic [1:0]  level;
    logic [2:0]  node_index;
    logic        below_root;
    logic [23:0] source_to_leaf_map;
    logic [7:0]  freed_leaves;
    logic [31:0] row_out;
    logic [31:0] extra_out;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // evaluate, update state, register the result word
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/bla_ctrl.sv =====
// Handshake controller for the buddy leaf context allocator.
// Sequences capture, execute and result delivery; depends on bla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bla_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bla_pkg::dp_cmd_t      cmd
);
  import bla_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign cmd.load  = in_valid && in_ready_r;
  assign cmd.exec  = (state_r == ST_EXEC);

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt    = ST_EXEC;
          in_ready_nxt = 1'b0;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_OUT;
        out_valid_nxt = 1'b1;
      end
      ST_OUT: begin
        // hold the result word until it is taken
        if (out_ready) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b0;
          in_ready_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
        in_ready_nxt  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input and result sides open at once");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("accepted word not executed next cycle");

  a_exec_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed word not presented");

endmodule

`default_nettype wire

// ===== src/bla_datapath.sv =====
// Datapath of the buddy leaf context allocator: context table, leaf
// free map, block search, leaf map and result register; depends on bla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bla_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bla_pkg::dp_cmd_t  cmd,
  input  wire bla_pkg::in_word_t in_data,
  output bla_pkg::out_word_t     out_data
);
  import bla_pkg::*;

  in_word_t    in_r;
  out_word_t   out_r, out_nxt;

  logic [NUM_CONTEXTS-1:0] busy_r, busy_nxt;
  logic [NUM_LEAVES-1:0]   free_r, free_nxt;
  logic [7:0]              gen_cnt_r;
  logic [31:0]             ctx_row_r    [NUM_CONTEXTS];
  logic [7:0]              ctx_gen_r    [NUM_CONTEXTS];
  logic [7:0]              ctx_leaves_r [NUM_CONTEXTS];

  logic                    is_release;
  logic [3:0]              pop_cnt;
  logic [1:0]              lvl;
  logic [7:0]              ones;
  logic [2:0]              align;
  logic                    have_ctx;
  logic [2:0]              free_ctx;
  logic                    have_blk;
  logic [2:0]              blk_base;
  logic [7:0]              blk_mask;
  logic [7:0]              cand;
  logic [3:0]              rank;
  logic [23:0]             leaf_map;
  logic                    rel_ok;
  logic                    grant;
  logic [7:0]              gen_inc;
  logic [7:0]              rel_bit;
  logic [7:0]              ctx_bit;

  assign is_release = (in_r.command == CMD_RELEASE);
  assign gen_inc    = gen_cnt_r + 8'd1;
  assign rel_bit    = 8'd1 << in_r.context_req;
  assign ctx_bit    = 8'd1 << free_ctx;

  always_comb begin
    pop_cnt = 4'd0;
    for (int i = 0; i < NUM_LEAVES; i++) begin
      pop_cnt = pop_cnt + {3'd0, in_r.src_select[i]};
    end
  end

  // round the source count up to a power-of-two block width
  always_comb begin
    if (pop_cnt <= 4'd1)      lvl = LEVEL_LEAF;
    else if (pop_cnt <= 4'd2) lvl = LEVEL_PAIR;
    else if (pop_cnt <= 4'd4) lvl = LEVEL_QUAD;
    else                      lvl = LEVEL_ROOT;
  end

  always_comb begin
    case (lvl)
      LEVEL_LEAF: begin ones = 8'h01; align = 3'd0; end
      LEVEL_PAIR: begin ones = 8'h03; align = 3'd1; end
      LEVEL_QUAD: begin ones = 8'h0f; align = 3'd3; end
      LEVEL_ROOT: begin ones = 8'hff; align = 3'd7; end
      default:    begin ones = 8'h01; align = 3'd0; end
    endcase
  end

  // lowest free context: scan downward so the lowest hit wins
  always_comb begin
    have_ctx = 1'b0;
    free_ctx = 3'd0;
    for (int i = NUM_CONTEXTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        have_ctx = 1'b1;
        free_ctx = 3'(i);
      end
    end
  end

  // lowest aligned block whose leaves are all free
  always_comb begin
    have_blk = 1'b0;
    blk_base = 3'd0;
    blk_mask = 8'd0;
    cand     = 8'd0;
    for (int b = NUM_LEAVES - 1; b >= 0; b--) begin
      cand = ones << b;
      if (((3'(b) & align) == 3'd0) && ((free_r & cand) == cand)) begin
        have_blk = 1'b1;
        blk_base = 3'(b);
        blk_mask = cand;
      end
    end
  end

  // each source maps to base plus the count of set sources below it
  always_comb begin
    rank     = 4'd0;
    leaf_map = 24'd0;
    for (int s = 0; s < NUM_LEAVES; s++) begin
      leaf_map[3*s +: 3] = blk_base + rank[2:0];
      rank = rank + {3'd0, in_r.src_select[s]};
    end
  end

  assign rel_ok = busy_r[in_r.context_req]
               && (ctx_gen_r[in_r.context_req] == in_r.generation)
               && (ctx_row_r[in_r.context_req] == in_r.row);

  assign grant = !is_release && (in_r.src_select != 8'd0) && have_ctx && have_blk;

  always_comb begin
    out_nxt         = '0;
    out_nxt.row_out = in_r.row;
    busy_nxt        = busy_r;
    free_nxt        = free_r;
    if (is_release) begin
      out_nxt.result_kind    = KIND_ACK;
      out_nxt.context_out    = in_r.context_req;
      out_nxt.generation_out = in_r.generation;
      if (rel_ok) begin
        out_nxt.status       = STATUS_OK;
        out_nxt.freed_leaves = ctx_leaves_r[in_r.context_req];
        free_nxt             = free_r | ctx_leaves_r[in_r.context_req];
        busy_nxt             = busy_r & ~rel_bit;
      end else begin
        out_nxt.status = STATUS_STALE;
      end
    end else begin
      out_nxt.result_kind = KIND_DISPATCH;
      out_nxt.extra_out   = in_r.extra;
      if (in_r.src_select == 8'd0) begin
        out_nxt.status = STATUS_EMPTY;
      end else if (!grant) begin
        out_nxt.status = STATUS_NO_ROOM;
      end else begin
        out_nxt.status             = STATUS_OK;
        out_nxt.context_out        = free_ctx;
        out_nxt.generation_out     = gen_inc;
        out_nxt.granted_leaves     = blk_mask;
        out_nxt.level              = lvl;
        out_nxt.node_index         = blk_base >> lvl;
        out_nxt.below_root         = (lvl != LEVEL_ROOT);
        out_nxt.source_to_leaf_map = leaf_map;
        busy_nxt                   = busy_r | ctx_bit;
        free_nxt                   = free_r & ~blk_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= '0;
      free_r    <= '1;
      gen_cnt_r <= 8'd0;
    end else if (cmd.exec) begin
      busy_r <= busy_nxt;
      free_r <= free_nxt;
      if (grant) begin
        gen_cnt_r <= gen_inc;
      end
    end
  end

  // payload: entries are only read while their context is busy
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
      if (grant) begin
        ctx_row_r[free_ctx]    <= in_r.row;
        ctx_gen_r[free_ctx]    <= gen_inc;
        ctx_leaves_r[free_ctx] <= blk_mask;
      end
    end
  end

  assign out_data = out_r;

  a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && grant) |=> ($countones(out_r.granted_leaves) == (32'd1 << out_r.level)))
    else $error("granted block width does not match level");

  a_grant_takes_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && grant) |=> ((free_r & $past(blk_mask)) == 8'd0))
    else $error("granted leaves still marked free");

  a_release_frees_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_release && rel_ok) |=> ((busy_r & $past(rel_bit)) == 8'd0))
    else $error("released context still busy");

endmodule

`default_nettype wire

// ===== src/buddy_leaf_context_allocator_core.sv =====
// Top level of the buddy leaf context allocator.
// Joins bla_ctrl and bla_datapath; depends on bla_pkg.
//
//   channel  direction  handshake            word
//   in_      input      in_valid/in_ready    bla_pkg::in_word_t
//   out_     output     out_valid/out_ready  bla_pkg::out_word_t
//
// A word is captured at its accepting edge and executed on the next edge,
// which registers the result. A new word is taken the cycle after its
// result leaves, so the block never holds more than one word at a time.
// Reset (rst_n low, synchronous) frees all leaves and contexts at once.
// A stalled result holds the block; input stays closed until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module buddy_leaf_context_allocator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bla_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bla_pkg::out_word_t      out_data
);
  import bla_pkg::*;

  dp_cmd_t cmd;

  bla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bla_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/bla_reply_checker.sv =====
// Scoreboard for the buddy leaf context allocator: keeps its own copy of the
// context table and free leaves, predicts one reply per accepted word and
// compares replies in order. Depends on bla_pkg.
`timescale 1ns / 1ps

module bla_reply_checker
  import bla_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_word_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_word_t out_data,
  output int             error_count,
  output int             replies_pending
);

  logic [7:0]  busy_set;
  logic [7:0]  free_set;
  logic [31:0] owner_row    [NUM_CONTEXTS];
  logic [7:0]  owner_gen    [NUM_CONTEXTS];
  logic [7:0]  owner_leaves [NUM_CONTEXTS];
  logic [7:0]  gen_counter;
  out_word_t   replies_due [$];
  int          reply_no;

  task automatic report_error(input string msg);
    if (error_count < 50) begin
      $display("[%0t] checker: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("reply %0d: %s is %h, expected %h", reply_no, name, got, want));
    end
  endtask

  // Apply one word to the tracked allocator state and return its reply.
  function automatic out_word_t resolve_word(input in_word_t w);
    out_word_t  r;
    logic [1:0] lvl;
    logic [7:0] cand;
    logic [7:0] blk;
    int         ones;
    int         span;
    int         base;
    int         ctx;
    int         rank;
    bit         found_ctx;
    bit         found_blk;
    r = '0;
    r.row_out = w.row;
    if (w.command == CMD_RELEASE) begin
      r.result_kind    = KIND_ACK;
      r.context_out    = w.context_req;
      r.generation_out = w.generation;
      if (busy_set[w.context_req] && owner_gen[w.context_req] == w.generation &&
          owner_row[w.context_req] == w.row) begin
        r.status       = STATUS_OK;
        r.freed_leaves = owner_leaves[w.context_req];
        free_set       = free_set | owner_leaves[w.context_req];
        busy_set[w.context_req]     = 1'b0;
        owner_leaves[w.context_req] = '0;
      end else begin
        r.status = STATUS_STALE;
      end
      return r;
    end

    r.result_kind = KIND_DISPATCH;
    r.extra_out   = w.extra;
    if (w.src_select == 8'h00) begin
      r.status = STATUS_EMPTY;
      return r;
    end

    ones = $countones(w.src_select);
    lvl  = ones <= 1 ? LEVEL_LEAF : ones <= 2 ? LEVEL_PAIR : ones <= 4 ? LEVEL_QUAD : LEVEL_ROOT;
    span = 1 << lvl;

    found_ctx = 1'b0;
    ctx       = 0;
    for (int c = 0; c < NUM_CONTEXTS; c++) begin
      if (!found_ctx && !busy_set[c]) begin
        ctx       = c;
        found_ctx = 1'b1;
      end
    end

    // lowest aligned block whose leaves are all free
    found_blk = 1'b0;
    base      = 0;
    blk       = '0;
    for (int b = 0; b < NUM_LEAVES; b += span) begin
      cand = 8'(((1 << span) - 1) << b);
      if (!found_blk && (free_set & cand) == cand) begin
        base      = b;
        blk       = cand;
        found_blk = 1'b1;
      end
    end

    if (!found_ctx || !found_blk) begin
      r.status = STATUS_NO_ROOM;
      return r;
    end

    gen_counter       = gen_counter + 8'd1;
    busy_set[ctx]     = 1'b1;
    free_set          = free_set & ~blk;
    owner_row[ctx]    = w.row;
    owner_gen[ctx]    = gen_counter;
    owner_leaves[ctx] = blk;

    r.status         = STATUS_OK;
    r.context_out    = 3'(ctx);
    r.generation_out = gen_counter;
    r.granted_leaves = blk;
    r.level          = lvl;
    r.node_index     = 3'(base >> lvl);
    r.below_root     = (lvl != LEVEL_ROOT);
    rank = 0;
    for (int s = 0; s < NUM_LEAVES; s++) begin
      r.source_to_leaf_map[3*s +: 3] = 3'(base + rank);
      rank += w.src_select[s];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      busy_set    = '0;
      free_set    = 8'hff;
      gen_counter = '0;
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        owner_row[i]    = '0;
        owner_gen[i]    = '0;
        owner_leaves[i] = '0;
      end
      replies_due.delete();
      reply_no    = 0;
      error_count = 0;
    end else begin
      // pop before push so a word accepted this edge never matches an older reply
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_error($sformatf("reply %0d arrived with nothing expected", reply_no));
        end else begin
          want = replies_due.pop_front();
          compare_field("result_kind", out_data.result_kind, want.result_kind);
          compare_field("status", out_data.status, want.status);
          compare_field("context_out", out_data.context_out, want.context_out);
          compare_field("generation_out", out_data.generation_out, want.generation_out);
          compare_field("granted_leaves", out_data.granted_leaves, want.granted_leaves);
          compare_field("level", out_data.level, want.level);
          compare_field("node_index", out_data.node_index, want.node_index);
          compare_field("below_root", out_data.below_root, want.below_root);
          compare_field("source_to_leaf_map", out_data.source_to_leaf_map,
                        want.source_to_leaf_map);
          compare_field("freed_leaves", out_data.freed_leaves, want.freed_leaves);
          compare_field("row_out", out_data.row_out, want.row_out);
          compare_field("extra_out", out_data.extra_out, want.extra_out);
        end
        reply_no++;
      end
      if (in_valid && in_ready) begin
        replies_due.push_back(resolve_word(in_data));
      end
    end
    replies_pending = replies_due.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the buddy leaf context allocator bench: clock, reset, word stimulus
// with bursts and stalls, and the verdict. Depends on bla_pkg, the core and
// bla_reply_checker.
`timescale 1ns / 1ps

module testbench;
  import bla_pkg::*;

  localparam int RANDOM_WORDS = 1725;
  localparam int DRAIN_EVERY  = 400;
  localparam int CYCLE_LIMIT  = 500000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        error_count;
  int        replies_pending;
  int        cycles    = 0;

  // contexts known to be held, used to aim releases at live grants
  logic [7:0]  live_set = '0;
  logic [7:0]  live_gen [NUM_CONTEXTS];
  logic [31:0] live_row [NUM_CONTEXTS];

  buddy_leaf_context_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bla_reply_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .error_count     (error_count),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.status == STATUS_OK) begin
      if (out_data.result_kind == KIND_DISPATCH) begin
        live_set[out_data.context_out] <= 1'b1;
        live_gen[out_data.context_out] <= out_data.generation_out;
        live_row[out_data.context_out] <= out_data.row_out;
      end else begin
        live_set[out_data.context_out] <= 1'b0;
      end
    end
  end

  // Receiver: change stall pattern after each randomly chosen span.
  initial begin : drain_pattern
    int mode;
    int span;
    int period;
    forever begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(40, 300);
      period = $urandom_range(2, 24);
      for (int phase = 0; phase < span; phase++) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (phase % period) >= (period / 2);
        endcase
      end
    end
  end

  function automatic in_word_t alloc_word(input logic [7:0] mask, input logic [31:0] row,
                                          input logic [31:0] extra);
    in_word_t w;
    w             = '0;
    w.command     = CMD_ALLOCATE;
    w.src_select  = mask;
    w.row         = row;
    w.extra       = extra;
    w.context_req = 3'($urandom);
    w.generation  = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t release_word(input logic [2:0] ctx, input logic [7:0] gen,
                                            input logic [31:0] row);
    in_word_t w;
    w             = '0;
    w.command     = CMD_RELEASE;
    w.context_req = ctx;
    w.generation  = gen;
    w.row         = row;
    w.extra       = $urandom;
    w.src_select  = 8'($urandom);
    return w;
  endfunction

  // Call right after a falling edge; hold the word until accepted.
  task automatic offer(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send(input in_word_t w);
    @(negedge clk);
    offer(w);
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_pending != 0) @(negedge clk);
  endtask

  // Mostly allocations and well-formed releases of live grants; some broken releases.
  task automatic compose_word(output in_word_t w);
    int pick;
    int sel;
    int c;
    int live_ids [$];
    logic [7:0] mask;
    for (int k = 0; k < NUM_CONTEXTS; k++) begin
      if (live_set[k]) live_ids.push_back(k);
    end
    pick = $urandom_range(0, 99);
    if (pick < 46 || live_ids.size() == 0) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) mask = 8'h00;
      else if (sel < 9) mask = 8'($urandom & $urandom & $urandom);
      else if (sel < 15) mask = 8'($urandom & $urandom);
      else mask = 8'($urandom);
      w = alloc_word(mask, $urandom, $urandom);
    end else begin
      c = live_ids[$urandom_range(0, live_ids.size() - 1)];
      w = release_word(3'(c), live_gen[c], live_row[c]);
      if (pick < 89) begin
        live_set[c] <= 1'b0;
      end else begin
        sel = $urandom_range(0, 2);
        case (sel)
          0:       w.row ^= 32'(1) << $urandom_range(0, 31);
          1:       w.generation ^= 8'($urandom_range(1, 255));
          default: w = release_word(3'($urandom), 8'($urandom), $urandom);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    in_word_t w;
    int sent;
    int burst;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send(alloc_word(8'h00, 32'hffff_ffff, 32'hffff_ffff));   // empty mask
    send(release_word(3'd0, 8'd0, 32'h0));                   // context never granted
    send(alloc_word(8'h80, 32'h0, 32'h0));                   // single leaf, ctx 0
    send(alloc_word(8'hff, 32'h1111_0001, 32'h5a5a_5a5a));   // root blocked
    send(alloc_word(8'h0a, 32'h2222_0002, 32'h1));           // pair
    send(alloc_word(8'h07, 32'h3333_0003, 32'h2));           // three sources round to quad
    send(alloc_word(8'h40, 32'h4444_0004, 32'h3));           // fills the last free leaf
    send(alloc_word(8'h03, 32'h5555_0005, 32'h4));           // no free block
    send(release_word(3'd0, 8'd1, 32'h1));                   // row mismatch
    send(release_word(3'd0, 8'd2, 32'h0));                   // generation mismatch
    send(release_word(3'd0, 8'd1, 32'h0));
    send(release_word(3'd1, 8'd2, 32'h2222_0002));
    send(release_word(3'd2, 8'd3, 32'h3333_0003));
    send(release_word(3'd3, 8'd4, 32'h4444_0004));
    send(alloc_word(8'hff, 32'hffff_ffff, 32'hffff_ffff));   // whole tree
    send(release_word(3'd7, 8'hff, 32'hffff_ffff));
    send(release_word(3'd0, 8'd5, 32'hffff_ffff));
    for (int i = 0; i < NUM_LEAVES; i++) begin
      send(alloc_word(8'(1 << i), $urandom, $urandom));
    end
    send(alloc_word(8'h01, $urandom, $urandom));              // every context busy
    drain();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        @(negedge clk);
        compose_word(w);
        offer(w);
        sent++;
        if (sent % DRAIN_EVERY == 0) drain();
      end
      if ($urandom_range(0, 3) == 0) idle($urandom_range(0, 1));
      else idle($urandom_range(1, 15));
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && replies_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
